/* sv/jffp_pkg.sv */
package jffp_pkg;

	localparam int BUFFER_BYTES_DEF = 128;
	localparam int JOINT_COUNT_DEF  = 8;

	localparam int ADDR_MAX_W      = 8;
	localparam int LEN_W           = 9;
	localparam int BYTES_PER_JOINT = 8;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] FEEDBACK_ID = 8'h02;

	localparam int ID_POS         = 2;
	localparam int LEN_POS        = 4;
	localparam int JOINT_BASE     = 5;
	localparam int FRAME_OVERHEAD = 6;
	localparam int RESET_LENGTH   = 14;
	localparam int GRIPPER_JOINT  = 7;
	localparam int GRIPPER_SPAN   = 50000;

	typedef struct packed {
		logic                  en;
		logic [ADDR_MAX_W-1:0] addr;
		logic [7:0]            data;
	} store_wr_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_ID,
		EM_FETCH,
		EM_LOAD
	} emit_state_t;

endpackage

/* sv/jffp_store.sv */
module jffp_store
	import jffp_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	localparam int AW = $clog2(BUFFER_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  store_wr_t     wr,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0]              mem [BUFFER_BYTES];
	logic [BUFFER_BYTES-1:0] valid_q;
	logic [7:0]              rd_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : 8'h00;

endmodule

/* sv/jffp_rx.sv */
module jffp_rx
	import jffp_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] rx_byte,
	input  logic      busy,
	output store_wr_t wr,
	output logic      start
);

	logic             in_frame_q;
	logic [7:0]       prev_q;
	logic [LEN_W-1:0] widx_q;
	logic [LEN_W-1:0] exp_q;
	logic [LEN_W-1:0] widx_n;
	logic [LEN_W-1:0] exp_n;
	logic             accept;

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;
	assign widx_n   = widx_q + LEN_W'(1);
	assign exp_n    = (widx_q == LEN_W'(LEN_POS))
		? LEN_W'(rx_byte) + LEN_W'(FRAME_OVERHEAD) : exp_q;

	assign wr.en   = accept && in_frame_q;
	assign wr.addr = widx_q[ADDR_MAX_W-1:0];
	assign wr.data = rx_byte;
	assign start   = wr.en && (widx_n == exp_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			prev_q     <= 8'h00;
			widx_q     <= '0;
			exp_q      <= LEN_W'(RESET_LENGTH);
		end else if (accept) begin
			if (!in_frame_q) begin
				if (prev_q == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
					in_frame_q <= 1'b1;
					widx_q     <= LEN_W'(ID_POS);
					prev_q     <= 8'h00;
				end else begin
					prev_q <= rx_byte;
				end
			end else begin
				exp_q  <= exp_n;
				widx_q <= widx_n;
				if (widx_n == exp_n || widx_n >= LEN_W'(BUFFER_BYTES)) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* sv/jffp_emit.sv */
module jffp_emit
	import jffp_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int JOINT_COUNT  = JOINT_COUNT_DEF,
	localparam int AW = $clog2(BUFFER_BYTES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [7:0]         rd_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         joint_index,
	output logic signed [31:0] joint_current,
	output logic signed [31:0] joint_position,
	output logic [31:0]        frames_seen,
	output logic               last_of_frame
);

	localparam int CNT_W = $clog2(BYTES_PER_JOINT + 1);
	localparam int RCV_W = $clog2(BYTES_PER_JOINT);

	emit_state_t        state_q, state_d;
	logic [AW-1:0]      addr_q;
	logic [CNT_W-1:0]   iss_q;
	logic [RCV_W-1:0]   rcv_q;
	logic               pend_s1;
	logic [63:0]        asm_q;
	logic [2:0]         joint_q;
	logic [31:0]        cnt_q;
	logic               out_valid_q;
	logic               slot_free;
	logic               last_joint;
	logic               fetch_done;
	logic [31:0]        pos_raw;
	logic [33:0]        grip_diff;
	logic [31:0]        grip_pos;
	logic [31:0]        pos_out;

	assign busy       = state_q != EM_IDLE;
	assign slot_free  = !out_valid_q || out_ready;
	assign last_joint = joint_q == 3'(JOINT_COUNT - 1);
	assign fetch_done = pend_s1 && rcv_q == RCV_W'(BYTES_PER_JOINT - 1);
	assign out_valid  = out_valid_q;

	assign pos_raw   = asm_q[31:0];
	assign grip_diff = 34'(GRIPPER_SPAN) - {{2{pos_raw[31]}}, pos_raw};

	always_comb begin
		if (grip_diff[33]) begin
			grip_pos = 32'd0;
		end else if (grip_diff > 34'(GRIPPER_SPAN)) begin
			grip_pos = 32'(GRIPPER_SPAN);
		end else begin
			grip_pos = grip_diff[31:0];
		end
		pos_out = (joint_q == 3'(GRIPPER_JOINT)) ? grip_pos : pos_raw;
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = addr_q;
		case (state_q)
			EM_IDLE: begin
				if (start) begin
					rd_en   = 1'b1;
					rd_addr = AW'(ID_POS);
					state_d = EM_ID;
				end
			end
			EM_ID: begin
				state_d = (rd_data == FEEDBACK_ID) ? EM_FETCH : EM_IDLE;
			end
			EM_FETCH: begin
				rd_en = iss_q != CNT_W'(BYTES_PER_JOINT);
				if (fetch_done) begin
					state_d = EM_LOAD;
				end
			end
			EM_LOAD: begin
				if (slot_free) begin
					state_d = last_joint ? EM_IDLE : EM_FETCH;
				end
			end
			default: begin
				state_d = EM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			pend_s1     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			joint_q     <= '0;
			iss_q       <= '0;
			rcv_q       <= '0;
			addr_q      <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == EM_FETCH) && rd_en;
			if (state_q == EM_LOAD && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				EM_ID: begin
					if (rd_data == FEEDBACK_ID) begin
						cnt_q   <= cnt_q + 32'd1;
						joint_q <= '0;
						addr_q  <= AW'(JOINT_BASE);
						iss_q   <= '0;
						rcv_q   <= '0;
					end
				end
				EM_FETCH: begin
					if (rd_en) begin
						addr_q <= addr_q + AW'(1);
						iss_q  <= iss_q + CNT_W'(1);
					end
					if (pend_s1) begin
						rcv_q <= rcv_q + RCV_W'(1);
					end
				end
				EM_LOAD: begin
					if (slot_free && !last_joint) begin
						joint_q <= joint_q + 3'd1;
						iss_q   <= '0;
						rcv_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EM_FETCH && pend_s1) begin
			asm_q <= {asm_q[55:0], rd_data};
		end
		if (state_q == EM_LOAD && slot_free) begin
			joint_index    <= joint_q;
			joint_current  <= asm_q[63:32];
			joint_position <= pos_out;
			frames_seen    <= cnt_q;
			last_of_frame  <= last_joint;
		end
	end

endmodule

/* sv/joint_feedback_frame_parser.sv */
// Serial feedback frame parser. Takes one received byte per cycle on rx_byte while in_ready is
// high. A frame opens after the bytes 0x55, 0xAA seen outside a frame; byte 4 gives the payload
// length and the frame is that length plus 6 bytes, ended early without results once
// BUFFER_BYTES bytes are held. Frame bytes go to a single-port-read buffer memory, cleared at
// reset through one valid flip-flop per entry, so no clearing pass is needed. When a frame
// completes, the id byte is read at the edge that takes the last byte, and in_ready then drops
// while results are read back: the id byte is checked, then for each joint 8 buffer reads go
// through the one read port, the last read data returns and the result is loaded. After an
// id 0x02 frame in_ready stays low until the last joint's result is loaded (longer if out_ready
// is held low), after any other id only for the id check. The last result may still wait in the
// output register while the next bytes are taken. Each result gives a joint's big-endian current
// and position; the gripper (joint 7) reports 50000 minus its position, clamped to 0..50000.
module joint_feedback_frame_parser
	import jffp_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int JOINT_COUNT  = JOINT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         joint_index,
	output logic signed [31:0] joint_current,
	output logic signed [31:0] joint_position,
	output logic [31:0]        frames_seen,
	output logic               last_of_frame
);

	localparam int AW = $clog2(BUFFER_BYTES);

	store_wr_t     wr;
	logic          start;
	logic          busy;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	jffp_rx #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte (rx_byte),
		.busy    (busy),
		.wr      (wr),
		.start   (start)
	);

	jffp_store #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	jffp_emit #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.JOINT_COUNT (JOINT_COUNT)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.joint_index   (joint_index),
		.joint_current (joint_current),
		.joint_position(joint_position),
		.frames_seen   (frames_seen),
		.last_of_frame (last_of_frame)
	);

	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !busy)
		else $error("buffer write while results are read back");

	a_last_is_final_joint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_frame |-> joint_index == 3'(JOINT_COUNT - 1))
		else $error("last_of_frame on wrong joint");

	a_gripper_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && joint_index == 3'(GRIPPER_JOINT)
		|-> joint_position >= 0 && joint_position <= GRIPPER_SPAN)
		else $error("gripper position out of range");

endmodule
